>>> sv/pcdt_pkg.sv
// Shared types and constants for the palette color dedup table.
`timescale 1ns / 1ps

package pcdt_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam int COLOR_W = 24;
   localparam int BYTE_W  = 8;

   typedef logic [COLOR_W-1:0] color_type;

   // Item travelling down the cell row
   typedef struct packed {
      logic              op;
      color_type         color;      // wanted color on insert, gathered color on read
      logic [BYTE_W-1:0] read_index;
      logic              done;       // insert resolved by some cell
      logic [BYTE_W-1:0] slot;       // low byte of the resolving cell's index
   } token_type;

endpackage

>>> sv/pcdt_cell.sv
// One palette slot: holds a color and passes the travelling item on.
`timescale 1ns / 1ps

module pcdt_cell #(
   parameter int CELL_INDEX = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  pcdt_pkg::token_type up_tok,
   output logic               dn_valid,
   output pcdt_pkg::token_type dn_tok
);
   import pcdt_pkg::*;

   localparam bit               IN_BYTE = (CELL_INDEX < 256);
   localparam logic [BYTE_W-1:0] IDX8   = CELL_INDEX[BYTE_W-1:0];

   color_type color_ff, color_in;
   logic      filled_ff, filled_in;
   token_type tok_ff, tok_in;
   logic      tok_valid_ff;

   always_comb begin
      tok_in    = up_tok;
      color_in  = color_ff;
      filled_in = filled_ff;
      if (up_valid) begin
         if (up_tok.op == OP_READ) begin
            if (IN_BYTE && (up_tok.read_index == IDX8)) begin
               tok_in.color = filled_ff ? color_ff : '0;
            end
         end else if (!up_tok.done) begin
            if (!filled_ff) begin
               // first empty slot: claim it unless the color is black
               tok_in.done = 1'b1;
               tok_in.slot = IDX8;
               if (up_tok.color != '0) begin
                  color_in  = up_tok.color;
                  filled_in = 1'b1;
               end
            end else if (color_ff == up_tok.color) begin
               tok_in.done = 1'b1;
               tok_in.slot = IDX8;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else if (advance) begin
         filled_ff    <= filled_in;
         tok_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff <= color_in;
         tok_ff   <= tok_in;
      end
   end

   assign dn_valid = tok_valid_ff;
   assign dn_tok   = tok_ff;

endmodule

>>> sv/palette_color_dedup_table_top.sv
// Top level of the palette color dedup table: cell row plus stream ports.
`timescale 1ns / 1ps
//
//  Channel | Direction | Beat contents
//  --------+-----------+--------------------------------------------------------
//  req_*   | in        | tdata: red, green, blue, read_index; tuser: op
//  rsp_*   | out       | tdata: slot, red, green, blue;       tuser: table_full
//
//  One item is in flight at a time. An accepted beat walks the row of
//  PALETTE_SLOTS-1 cells, one cell per cycle while the row is not frozen, and
//  lands in the output register, raising rsp_tvalid. req_tready rises in that
//  same cycle, so the next beat is taken only once the previous one has left
//  the row. Synchronous reset empties every slot.
//  A result waiting on rsp_tready does not block the next accept; the row
//  freezes only if that next item reaches the end before the result is taken.
//
module palette_color_dedup_table_top #(
   parameter int PALETTE_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], read_index[31:24]
   input  logic [0:0]  req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // slot[7:0], red[15:8], green[23:16], blue[31:24]
   output logic [0:0]  rsp_tuser    // table_full[0]
);
   import pcdt_pkg::*;

   localparam int LAST = PALETTE_SLOTS - 1;

   token_type               chain_tok   [PALETTE_SLOTS];
   logic [PALETTE_SLOTS-1:0] chain_valid;

   logic        busy_ff, busy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [0:0]  rsp_user_ff, rsp_user_in;
   logic        req_fire, rsp_fire, exit_valid, advance;
   token_type   exit_tok;
   color_type   entry_color;

   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign exit_valid = chain_valid[LAST];
   assign exit_tok   = chain_tok[LAST];

   // Freeze the row only while the finished item has nowhere to go
   assign advance = !(exit_valid && rsp_valid_ff && !rsp_tready);

   // Build the entering item; reads carry black so cells can drop their color in
   assign entry_color    = (req_tuser[0] == OP_READ) ? '0 :
                           {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
   assign chain_valid[0] = req_fire;
   assign chain_tok[0]   = {req_tuser[0], entry_color, req_tdata[31:24], 1'b0,
                            {BYTE_W{1'b0}}};

   for (genvar g = 1; g < PALETTE_SLOTS; g++) begin : g_cell
      pcdt_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (chain_valid[g-1]),
         .up_tok   (chain_tok[g-1]),
         .dn_valid (chain_valid[g]),
         .dn_tok   (chain_tok[g])
      );
   end

   // Output register and busy flag
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
      if (exit_valid && advance) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         if (exit_tok.op == OP_READ) begin
            rsp_data_in = {exit_tok.color[7:0], exit_tok.color[15:8],
                           exit_tok.color[23:16], 8'd0};
            rsp_user_in = 1'b0;
         end else begin
            // insert: report the resolving slot; if no cell resolved it, every slot holds another color
            rsp_data_in = {24'd0, exit_tok.done ? exit_tok.slot : 8'd0};
            rsp_user_in = !exit_tok.done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> sv/pcdt_checker.sv
// Port-level checks for the palette color dedup table, bound to the top level.
`timescale 1ns / 1ps

module pcdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while one is in flight");

   // a full-table result reports slot zero and no color
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("full flag with nonzero payload");

   // a result carrying color is a read: slot and full flag are zero
   a_read_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[31:8] != 24'd0) |-> rsp_tdata[7:0] == 8'd0 && !rsp_tuser[0])
      else $error("read result mixed with insert fields");

endmodule

bind palette_color_dedup_table_top pcdt_checker u_checker (.*);

>>> bench/pcdt_checker.sv
// Scoreboard that predicts and checks palette color dedup table responses.
`timescale 1ns / 1ps

module pcdt_scoreboard #(
   parameter int PALETTE_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], read_index[31:24]
   input  logic [0:0]  req_tuser,   // op[0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // slot[7:0], red[15:8], green[23:16], blue[31:24]
   input  logic [0:0]  rsp_tuser,   // table_full[0]
   output int          mismatches,
   output int          pending,
   output int          slots_filled,
   output int          full_replies
);
   import pcdt_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] slot;
      logic              table_full;
      color_type         color;       // {red, green, blue}
   } palette_reply_type;

   color_type         palette_mem [PALETTE_SLOTS];
   palette_reply_type reply_q [$];
   palette_reply_type oldest_reply;
   int                err_cnt;
   int                used_cnt;
   int                full_cnt;
   int                pending_cnt;

   assign mismatches   = err_cnt;
   assign pending      = pending_cnt;
   assign slots_filled = used_cnt;
   assign full_replies = full_cnt;

   // Scan slots 1 upward: first match or first empty slot wins; black is never stored.
   function automatic palette_reply_type predict_palette_reply(logic op, color_type want,
                                                               logic [BYTE_W-1:0] idx);
      palette_reply_type reply;
      int                k;
      bit                hit;
      reply = '0;
      hit   = 1'b0;
      if (op == OP_READ) begin
         if (idx < PALETTE_SLOTS) reply.color = palette_mem[idx];
         return reply;
      end
      for (k = 1; k < PALETTE_SLOTS; k++) begin
         if (palette_mem[k] == '0) begin
            if (want != '0) begin
               palette_mem[k] = want;
               used_cnt++;
            end
            hit = 1'b1;
            break;
         end
         if (palette_mem[k] == want) begin
            hit = 1'b1;
            break;
         end
      end
      if (hit) begin
         reply.slot = k[BYTE_W-1:0];
      end else begin
         reply.table_full = 1'b1;
         full_cnt++;
      end
      return reply;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         err_cnt++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_SLOTS; i++) palette_mem[i] = '0;
         reply_q.delete();
         err_cnt     = 0;
         used_cnt    = 0;
         full_cnt    = 0;
         pending_cnt = 0;
      end else begin
         // Check first so a beat with nothing queued is never masked by a new push.
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               $display("%0t ns: unexpected response beat, expected none, actual %0h/%0h",
                        $time, rsp_tdata, rsp_tuser);
               err_cnt++;
            end else begin
               oldest_reply = reply_q.pop_front();
               check_field("slot",       oldest_reply.slot,        rsp_tdata[7:0]);
               check_field("table_full", {7'd0, oldest_reply.table_full}, {7'd0, rsp_tuser[0]});
               check_field("red",        oldest_reply.color[23:16], rsp_tdata[15:8]);
               check_field("green",      oldest_reply.color[15:8],  rsp_tdata[23:16]);
               check_field("blue",       oldest_reply.color[7:0],   rsp_tdata[31:24]);
            end
         end
         if (req_tvalid && req_tready)
            reply_q.push_back(predict_palette_reply(req_tuser[0],
                                                    {req_tdata[7:0], req_tdata[15:8],
                                                     req_tdata[23:16]},
                                                    req_tdata[31:24]));
         pending_cnt = reply_q.size();
      end
   end

endmodule

>>> bench/palette_color_dedup_table_top_test.sv
// Stimulus and verdict for the palette color dedup table.
`timescale 1ns / 1ps

module palette_color_dedup_table_top_test;
   import pcdt_pkg::*;

   localparam int SLOTS       = 256;
   localparam int RANDOM_BEATS = 1625;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // red[7:0], green[15:8], blue[23:16], read_index[31:24]
   logic [0:0]  req_tuser;   // op[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // slot[7:0], red[15:8], green[23:16], blue[31:24]
   logic [0:0]  rsp_tuser;   // table_full[0]

   int          mismatches;
   int          pending;
   int          slots_filled;
   int          full_replies;

   // Burst flags: while set, the side in question never idles.
   bit          quiet_send;
   bit          quiet_recv;
   int          insert_cnt;
   int          read_cnt;
   color_type   seen_colors [$];

   palette_color_dedup_table_top #(
      .PALETTE_SLOTS(SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pcdt_scoreboard #(
      .PALETTE_SLOTS(SLOTS)
   ) u_scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .mismatches   (mismatches),
      .pending      (pending),
      .slots_filled (slots_filled),
      .full_replies (full_replies)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drive one request beat. Entered at a falling edge right after the previous
   // accept (or after valid was dropped); leaves at the falling edge after this
   // beat is taken. Lower valid only when a gap follows, so it never toggles
   // twice in one step.
   task automatic send_beat(logic op, logic [7:0] red, logic [7:0] green,
                            logic [7:0] blue, logic [7:0] read_index);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {read_index, blue, green, red};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (op == OP_READ) read_cnt++;
      else insert_cnt++;
   endtask

   task automatic send_color(color_type color);
      send_beat(OP_INSERT, color[23:16], color[15:8], color[7:0], 8'($urandom));
   endtask

   task automatic send_read(logic [7:0] read_index);
      send_beat(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), read_index);
   endtask

   // Response side: hold tready low for a drawn stall, then raise it until a beat is taken.
   initial begin : rsp_side
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet_recv ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int        pick;
      color_type color;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_INSERT;
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
      insert_cnt = 0;
      read_cnt   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table reads, black on an empty table, duplicates,
      // single-bit colors, black after a few stores, read-back.
      send_read(8'h00);
      send_read(8'hFF);
      send_color(24'h000000);          // black: reports slot 1, stores nothing
      send_color(24'hFFFFFF);          // lands in slot 1
      send_color(24'hFFFFFF);          // hit on slot 1
      send_color(24'h010000);
      send_color(24'h000001);
      send_color(24'h000100);
      send_color(24'h000000);          // black: next free index
      send_color(24'h808080);
      send_color(24'h010000);          // hit deeper in the table
      send_read(8'h01);
      send_read(8'h05);
      send_read(8'h00);                // slot 0 stays black
      send_read(8'h06);                // first empty slot
      send_read(8'h80);
      send_beat(OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'h02);
      send_beat(OP_INSERT, 8'h7F, 8'h7F, 8'h7F, 8'hFF);
      seen_colors = '{24'hFFFFFF, 24'h010000, 24'h000001, 24'h000100, 24'h808080,
                      24'h7F7F7F};

      // Random: mostly repeats and fresh colors so the table fills and then
      // runs full for the rest of the run; reads and black inserts mixed in.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 64 == 0) begin
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_recv = ($urandom_range(0, 3) == 0);
         end
         // Drain: drop valid and hold off until every response is back.
         if (n == 400 || n == 1100) begin
            req_tvalid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            send_read(8'($urandom));
         end else if (pick < 25) begin
            send_color(24'h000000);
         end else if (pick < 65) begin
            send_color(seen_colors[$urandom_range(0, seen_colors.size() - 1)]);
         end else begin
            color = color_type'($urandom);
            send_color(color);
            if (color != '0) seen_colors.push_back(color);
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then allow one full walk of the cell row for stray beats.
      wait (pending == 0);
      repeat (SLOTS + 50) @(negedge clock);
      $display("Sent %0d inserts and %0d reads with random gaps and stalls.",
               insert_cnt, read_cnt);
      $display("Palette reached %0d of %0d slots; %0d inserts hit a full table.",
               slots_filled, SLOTS - 1, full_replies);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #25_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
